// File: hw/rtl/wsp_integer_length_encoder_assert.svh
// Assertion macros for the WSP integer and length encoder
`ifndef WSP_INTEGER_LENGTH_ENCODER_ASSERT_SVH
`define WSP_INTEGER_LENGTH_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define WILE_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define WILE_ASSERT_NXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: hw/rtl/wile_pkg.sv
// Shared types and constants of the WSP integer and length encoder
package wile_pkg;

	localparam int POS_W       = 21;
	localparam int NBYTES      = 9;
	localparam int CNT_W       = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [POS_W-1:0] LIMIT_RESET   = 21'd65536;
	localparam logic [7:0]       CONT_BIT      = 8'h80;
	localparam logic [7:0]       QUOTE_BYTE    = 8'h1F;
	localparam logic [31:0]      SHORT_LEN_MAX = 32'd30;
	localparam logic [31:0]      SHORT_INT_MAX = 32'd127;

	typedef enum logic [2:0] {
		KIND_UINTVAR      = 3'd0,
		KIND_VALUE_LENGTH = 3'd1,
		KIND_INTEGER      = 3'd2,
		KIND_LONG_INTEGER = 3'd3,
		KIND_SHORT_INT    = 3'd4,
		KIND_SHORT_LENGTH = 3'd5,
		KIND_OCTET        = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORTLEN = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	// One classified request: bytes in buffer order, first at index 0
	typedef struct packed {
		logic [NBYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]       cnt;
		logic                   short_err;
		logic                   new_pdu;
	} cmd_t;

endpackage

// File: hw/rtl/wile_front.sv
// Front end: accepts requests and expands them into encoded byte lists
module wile_front
	import wile_pkg::*;
(
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [63:0] value,
	input  logic        new_pdu,
	input  logic        full,
	output logic        push,
	output cmd_t        cmd
);

	typedef struct packed {
		logic [4:0][7:0] b;
		logic [2:0]      n;
	} uv_t;

	typedef struct packed {
		logic [8:0][7:0] b;
		logic [3:0]      n;
	} li_t;

	// 7-bit groups, most significant first, continuation bit on all but the last
	function automatic uv_t uintvar(input logic [31:0] v);
		uv_t             r;
		logic [4:0][6:0] grp;
		logic [2:0]      sel;
		for (int k = 0; k < 4; k++)
			grp[k] = v[7*k +: 7];
		grp[4] = {3'd0, v[31:28]};
		priority if (v[31:28] != 4'd0) r.n = 3'd5;
		else if (v[27:21] != 7'd0)     r.n = 3'd4;
		else if (v[20:14] != 7'd0)     r.n = 3'd3;
		else if (v[13:7] != 7'd0)      r.n = 3'd2;
		else                           r.n = 3'd1;
		r.b = '0;
		for (int j = 0; j < 5; j++) begin
			sel = r.n - 3'd1 - 3'(j);
			if (3'(j) < r.n)
				r.b[j] = {(3'(j) != r.n - 3'd1), grp[sel]};
		end
		return r;
	endfunction

	// Count byte, then the significant bytes big-endian; zero takes one byte
	function automatic li_t long_int(input logic [63:0] v);
		li_t        r;
		logic [3:0] c;
		logic [3:0] t;
		c = 4'd1;
		for (int i = 0; i < 8; i++)
			if (v[8*i +: 8] != 8'd0)
				c = 4'(i + 1);
		r.b = '0;
		r.n = c + 4'd1;
		r.b[0] = {4'd0, c};
		for (int j = 0; j < 8; j++) begin
			t = c - 4'd1 - 4'(j);
			if (4'(j) < c)
				r.b[j+1] = v[{t[2:0], 3'b000} +: 8];
		end
		return r;
	endfunction

	logic [31:0] v32;
	logic [7:0]  v8;
	logic [63:0] li_in;
	uv_t         uv;
	li_t         li;

	assign v32   = value[31:0];
	assign v8    = value[7:0];
	assign li_in = (kind_t'(req_type) == KIND_LONG_INTEGER) ? value : {32'd0, v32};
	assign uv    = uintvar(v32);
	assign li    = long_int(li_in);

	assign in_stall = full;
	assign push     = in_valid && !full;

	always_comb begin
		cmd           = '0;
		cmd.new_pdu   = new_pdu;
		unique case (kind_t'(req_type))
			KIND_UINTVAR: begin
				cmd.bytes[4:0] = uv.b;
				cmd.cnt        = {1'b0, uv.n};
			end
			KIND_VALUE_LENGTH: begin
				if (v32 <= SHORT_LEN_MAX) begin
					cmd.bytes[0] = v8;
					cmd.cnt      = 4'd1;
				end else begin
					cmd.bytes[0]   = QUOTE_BYTE;
					cmd.bytes[5:1] = uv.b;
					cmd.cnt        = {1'b0, uv.n} + 4'd1;
				end
			end
			KIND_INTEGER: begin
				if (v32 <= SHORT_INT_MAX) begin
					cmd.bytes[0] = v8 | CONT_BIT;
					cmd.cnt      = 4'd1;
				end else begin
					cmd.bytes = li.b;
					cmd.cnt   = li.n;
				end
			end
			KIND_LONG_INTEGER: begin
				cmd.bytes = li.b;
				cmd.cnt   = li.n;
			end
			KIND_SHORT_INT: begin
				cmd.bytes[0] = v8 | CONT_BIT;
				cmd.cnt      = 4'd1;
			end
			KIND_SHORT_LENGTH: begin
				if ({24'd0, v8} > SHORT_LEN_MAX) begin
					cmd.short_err = 1'b1;
				end else begin
					cmd.bytes[0] = v8;
					cmd.cnt      = 4'd1;
				end
			end
			KIND_OCTET: begin
				cmd.bytes[0] = v8;
				cmd.cnt      = 4'd1;
			end
			// Undefined kind: no bytes, only the position clear takes effect
			default: begin
				cmd.cnt = '0;
			end
		endcase
	end

endmodule

// File: hw/rtl/wile_queue.sv
// Small command queue between the front end and the byte emitter
module wile_queue
	import wile_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
)
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr,
	input  logic pop,
	output cmd_t rd,
	output logic full,
	output logic empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd    = mem[rptr_q];
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem[wptr_q] <= wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			if (pop)
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// File: hw/rtl/wile_back.sv
// Back end: walks a command's bytes, checks the buffer limit, drives results
module wile_back
	import wile_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [POS_W-1:0] cfg_data,
	input  cmd_t             rd,
	input  logic             empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic [POS_W-1:0] byte_position,
	output logic [1:0]       status,
	output logic             last
);

	typedef enum logic {
		S_IDLE,
		S_EMIT
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] idx_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] limit_q;
	logic             ovalid_q;
	logic [7:0]       byte_q;
	logic [POS_W-1:0] opos_q;
	status_t          status_q;
	logic             last_q;
	logic             can_emit;

	assign can_emit      = !ovalid_q || !out_stall;
	assign pop           = (state_q == S_IDLE) && !empty;
	assign out_valid     = ovalid_q;
	assign out_byte      = byte_q;
	assign byte_position = opos_q;
	assign status        = status_q;
	assign last          = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pos_q    <= '0;
			limit_q  <= LIMIT_RESET;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				limit_q <= cfg_data;
			// load a new result, or drop the one just taken
			if ((state_q == S_EMIT) && can_emit)
				ovalid_q <= 1'b1;
			else if (!out_stall)
				ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						cmd_q <= rd;
						idx_q <= '0;
						if (rd.new_pdu)
							pos_q <= '0;
						if (rd.cnt != '0 || rd.short_err)
							state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (can_emit) begin
						opos_q <= pos_q;
						priority if (cmd_q.short_err) begin
							byte_q   <= '0;
							last_q   <= 1'b1;
							status_q <= ST_SHORTLEN;
							state_q  <= S_IDLE;
						end else if (pos_q >= limit_q) begin
							// drop the rest of the request; position stays
							byte_q   <= '0;
							last_q   <= 1'b1;
							status_q <= ST_FULL;
							state_q  <= S_IDLE;
						end else begin
							byte_q   <= cmd_q.bytes[idx_q];
							status_q <= ST_OK;
							last_q   <= (idx_q == cmd_q.cnt - CNT_W'(1));
							pos_q    <= pos_q + POS_W'(1);
							idx_q    <= idx_q + CNT_W'(1);
							if (idx_q == cmd_q.cnt - CNT_W'(1))
								state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/wsp_integer_length_encoder.sv
// Top level of the WSP uintvar, length and integer encoder
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid, in_stall, req_type, value, new_pdu | request in
//   out     | out_valid, out_stall, out_byte, byte_position, status, last | bytes out
//   cfg     | cfg_valid, cfg_ready, buffer_limit         | limit write
//
// The emitter loads a request while idle, then emits its results in order while out_stall allows;
// a request of undefined kind is popped without producing a result.
// The emitter's byte loop sets the rate; the front end takes a request each cycle while the
// command queue has room.
// Reset clears the write position and the queue and sets the buffer limit to 65536.
// out_stall holds the result register and the emitter; a full queue raises in_stall.
module wsp_integer_length_encoder
	import wile_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       req_type,
	input  logic [63:0]      value,
	input  logic             new_pdu,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic [POS_W-1:0] byte_position,
	output logic [1:0]       status,
	output logic             last,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [POS_W-1:0] buffer_limit
);

`include "wsp_integer_length_encoder_assert.svh"

	cmd_t q_wr;
	cmd_t q_rd;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	logic out_err;
	logic q_load;

	assign cfg_ready = 1'b1;
	assign out_err   = out_valid && (status != ST_OK);
	assign q_load    = q_pop && (q_rd.cnt != '0 || q_rd.short_err);

	wile_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.value    (value),
		.new_pdu  (new_pdu),
		.full     (q_full),
		.push     (q_push),
		.cmd      (q_wr)
	);

	wile_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr     (q_wr),
		.pop    (q_pop),
		.rd     (q_rd),
		.full   (q_full),
		.empty  (q_empty)
	);

	wile_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (buffer_limit),
		.rd            (q_rd),
		.empty         (q_empty),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.byte_position (byte_position),
		.status        (status),
		.last          (last)
	);

	`WILE_ASSERT_IMP(a_err_is_last, out_err, last, "error result not last")
	`WILE_ASSERT_IMP(a_err_zero_byte, out_err, out_byte == 8'd0, "error result carries a byte")
	`WILE_ASSERT_NXT(a_pop_then_busy, q_load, !q_pop, "queue popped while emitting")

endmodule

// File: verif/wsp_integer_length_encoder_tb.sv
// Self-checking testbench for the WSP uintvar, length and integer encoder
`timescale 1ns / 100ps

module wsp_integer_length_encoder_tb;
	import wile_pkg::*;

	localparam logic [2:0] KIND_UNDEF  = 3'd7;
	localparam int         TAIL_CYCLES = 48;
	localparam int         RAND_PHASES = 8;
	localparam int         PHASE_ITEMS = 20;

	typedef struct {
		logic [7:0]       data;
		logic [POS_W-1:0] pos;
		status_t          st;
		logic             fin;
	} enc_byte_t;

	typedef struct {
		logic [2:0]  kind;
		logic [63:0] val;
		logic        np;
		bit          typed;
		logic [7:0]  tbyte;
		status_t     tst;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [2:0]       req_type;
	logic [63:0]      value;
	logic             new_pdu;
	logic             out_valid;
	logic             out_stall;
	logic [7:0]       out_byte;
	logic [POS_W-1:0] byte_position;
	logic [1:0]       status;
	logic             last;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [POS_W-1:0] buffer_limit;

	// predictor state
	logic [POS_W-1:0] wr_pos;
	logic [POS_W-1:0] buf_limit;
	enc_byte_t        pending_bytes[$];
	enc_byte_t        head;

	bit calm;
	int errors;
	int items_sent;
	int undef_sent;
	int results_seen;
	int full_seen;
	int shortlen_seen;

	// directed walk: typed rows carry their one result, the rest go through the predictor
	stim_row_t directed [25] = '{
		'{KIND_UINTVAR,      64'd0,                   1'b1, 1'b1, 8'h00, ST_OK},
		'{KIND_UINTVAR,      64'd127,                 1'b0, 1'b0, 8'h00, ST_OK},
		'{KIND_UINTVAR,      64'd128,                 1'b0, 1'b0, 8'h00, ST_OK},
		'{KIND_UINTVAR,      64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 8'h00, ST_OK},
		'{KIND_VALUE_LENGTH, 64'd0,                   1'b0, 1'b1, 8'h00, ST_OK},
		'{KIND_VALUE_LENGTH, 64'd30,                  1'b0, 1'b1, 8'h1E, ST_OK},
		'{KIND_VALUE_LENGTH, 64'd31,                  1'b0, 1'b0, 8'h00, ST_OK},
		'{KIND_VALUE_LENGTH, 64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0, 8'h00, ST_OK},
		'{KIND_INTEGER,      64'd0,                   1'b0, 1'b1, 8'h80, ST_OK},
		'{KIND_INTEGER,      64'd127,                 1'b0, 1'b1, 8'hFF, ST_OK},
		'{KIND_INTEGER,      64'd128,                 1'b0, 1'b0, 8'h00, ST_OK},
		'{KIND_INTEGER,      64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 8'h00, ST_OK},
		'{KIND_LONG_INTEGER, 64'd0,                   1'b0, 1'b0, 8'h00, ST_OK},
		'{KIND_LONG_INTEGER, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 8'h00, ST_OK},
		'{KIND_LONG_INTEGER, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 8'h00, ST_OK},
		'{KIND_SHORT_INT,    64'd0,                   1'b0, 1'b1, 8'h80, ST_OK},
		'{KIND_SHORT_INT,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 8'hFF, ST_OK},
		'{KIND_SHORT_LENGTH, 64'd30,                  1'b0, 1'b1, 8'h1E, ST_OK},
		'{KIND_SHORT_LENGTH, 64'd31,                  1'b0, 1'b1, 8'h00, ST_SHORTLEN},
		'{KIND_SHORT_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 8'h00, ST_SHORTLEN},
		'{KIND_SHORT_LENGTH, 64'h0000_0000_0000_0100, 1'b0, 1'b1, 8'h00, ST_OK},
		'{KIND_OCTET,        64'd0,                   1'b0, 1'b1, 8'h00, ST_OK},
		'{KIND_OCTET,        64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 8'hFF, ST_OK},
		'{KIND_UNDEF,        64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 8'h00, ST_OK},
		'{KIND_OCTET,        64'h5A,                  1'b0, 1'b1, 8'h5A, ST_OK}
	};

	logic [POS_W-1:0] phase_limit [RAND_PHASES] = '{
		21'd5, 21'd0, 21'd1, 21'd1048576, 21'h1FFFFF, 21'd40, 21'd3, 21'd0
	};

	wsp_integer_length_encoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.value        (value),
		.new_pdu      (new_pdu),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_position(byte_position),
		.status       (status),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.buffer_limit (buffer_limit)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void add_uintvar(ref logic [7:0] seq[$], input logic [31:0] v);
		logic [7:0] grp[$];
		grp.push_front({1'b0, v[6:0]});
		v = v >> 7;
		while (v != 0) begin
			grp.push_front(CONT_BIT | {1'b0, v[6:0]});
			v = v >> 7;
		end
		foreach (grp[g])
			seq.push_back(grp[g]);
	endfunction

	function automatic void add_long_integer(ref logic [7:0] seq[$], input logic [63:0] v);
		logic [63:0] t;
		int cnt;
		t = v;
		cnt = 0;
		while (t != 0) begin
			cnt++;
			t = t >> 8;
		end
		if (cnt == 0)
			cnt = 1;
		seq.push_back(8'(cnt));
		for (int i = cnt - 1; i >= 0; i--)
			seq.push_back(v[8*i +: 8]);
	endfunction

	// Encode one request against the tracked position and limit; advance the position
	function automatic void encode_request(input logic [2:0] kind, input logic [63:0] val,
			input logic np, output enc_byte_t res[$]);
		logic [7:0]  seq[$];
		logic [31:0] v32;
		res = {};
		v32 = val[31:0];
		if (np)
			wr_pos = '0;
		case (kind)
			KIND_UINTVAR: add_uintvar(seq, v32);
			KIND_VALUE_LENGTH: begin
				if (v32 <= SHORT_LEN_MAX)
					seq.push_back(v32[7:0]);
				else begin
					seq.push_back(QUOTE_BYTE);
					add_uintvar(seq, v32);
				end
			end
			KIND_INTEGER: begin
				if (v32 <= SHORT_INT_MAX)
					seq.push_back(v32[7:0] | CONT_BIT);
				else
					add_long_integer(seq, {32'd0, v32});
			end
			KIND_LONG_INTEGER: add_long_integer(seq, val);
			KIND_SHORT_INT: seq.push_back(val[7:0] | CONT_BIT);
			KIND_SHORT_LENGTH: begin
				if ({24'd0, val[7:0]} > SHORT_LEN_MAX) begin
					res.push_back('{8'd0, wr_pos, ST_SHORTLEN, 1'b1});
					return;
				end
				seq.push_back(val[7:0]);
			end
			KIND_OCTET: seq.push_back(val[7:0]);
			default: return;
		endcase
		foreach (seq[k]) begin
			// the byte that does not fit ends the request
			if (wr_pos >= buf_limit) begin
				res.push_back('{8'd0, wr_pos, ST_FULL, 1'b1});
				return;
			end
			res.push_back('{seq[k], wr_pos, ST_OK, k == seq.size() - 1});
			wr_pos = wr_pos + 1'b1;
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH at %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
		errors++;
	endtask

	task automatic send_request(input logic [2:0] kind, input logic [63:0] val,
			input logic np, input bit typed, input logic [7:0] tbyte, input status_t tst);
		int gap;
		enc_byte_t res[$];
		enc_byte_t one;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		req_type = kind;
		value = val;
		new_pdu = np;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		if (kind == KIND_UNDEF)
			undef_sent++;
		encode_request(kind, val, np, res);
		if (typed) begin
			one = res[0];
			one.data = tbyte;
			one.st = tst;
			one.fin = 1'b1;
			pending_bytes.push_back(one);
		end else begin
			foreach (res[k])
				pending_bytes.push_back(res[k]);
		end
	endtask

	task automatic send_random();
		logic [2:0]  kind;
		logic [63:0] val;
		logic        np;
		kind = ($urandom_range(0, 15) == 0) ? KIND_UNDEF : 3'($urandom_range(0, 6));
		val = {$urandom(), $urandom()} >> $urandom_range(0, 63);
		if (kind == KIND_SHORT_LENGTH && $urandom_range(0, 1))
			val[7:0] = 8'($urandom_range(0, 30));
		// restart the PDU more often when the buffer is tiny, so bytes still get through
		if (buf_limit < 64)
			np = ($urandom_range(0, 2) == 0);
		else
			np = ($urandom_range(0, 7) == 0);
		send_request(kind, val, np, 1'b0, 8'h00, ST_OK);
	endtask

	// Hold off the sender until every expected byte has come out
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [POS_W-1:0] lim);
		@(negedge clk);
		cfg_valid = 1'b1;
		buffer_limit = lim;
		do
			@(posedge clk);
		while (!cfg_ready);
		buf_limit = lim;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// output side stall pattern
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			n = pick_gap();
			if (n > 0) begin
				@(negedge clk);
				out_stall = 1'b1;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_bytes.size() == 0)
				report_mismatch("unexpected transaction, out_byte", out_byte, 64'd0);
			else begin
				head = pending_bytes.pop_front();
				if (head.st == ST_FULL)
					full_seen++;
				if (head.st == ST_SHORTLEN)
					shortlen_seen++;
				if (out_byte !== head.data)
					report_mismatch("out_byte", out_byte, head.data);
				if (byte_position !== head.pos)
					report_mismatch("byte_position", byte_position, head.pos);
				if (status !== head.st)
					report_mismatch("status", status, head.st);
				if (last !== head.fin)
					report_mismatch("last", last, head.fin);
			end
		end
	end

	initial begin
		#8ms;
		$display("Timeout with %0d bytes still expected", pending_bytes.size());
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = '0;
		value = '0;
		new_pdu = 1'b0;
		cfg_valid = 1'b0;
		buffer_limit = '0;
		calm = 1'b0;
		errors = 0;
		items_sent = 0;
		undef_sent = 0;
		results_seen = 0;
		full_seen = 0;
		shortlen_seen = 0;
		wr_pos = '0;
		buf_limit = LIMIT_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[r])
			send_request(directed[r].kind, directed[r].val, directed[r].np,
				directed[r].typed, directed[r].tbyte, directed[r].tst);
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == RAND_PHASES - 1)
				write_limit(21'($urandom_range(2, 200)));
			else
				write_limit(phase_limit[p]);
			calm = (p == 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_random();
				if (p == 5 && i == 10)
					drain();
			end
			drain();
		end
		calm = 1'b0;

		$display("Ran %0d requests (%0d of undefined kind) across %0d buffer limits",
			items_sent, undef_sent, RAND_PHASES + 1);
		$display("Checked %0d output bytes, %0d buffer-full and %0d short-length errors",
			results_seen, full_seen, shortlen_seen);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/wile_pkg.sv
hw/rtl/wile_front.sv
hw/rtl/wile_queue.sv
hw/rtl/wile_back.sv
hw/rtl/wsp_integer_length_encoder.sv
verif/wsp_integer_length_encoder_tb.sv
